/* hw/rtl/gre_pkg.sv */
package gre_pkg;

	// Item kinds on the input channel.
	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_QUERY = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_PIVOT,
		ST_SELECT,
		ST_COUNT,
		ST_DONE
	} state_t;

	// Largest value the reach_count field can show.
	localparam logic [6:0] COUNT_MAX = 7'd127;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic add_edge;
		logic clear;
		logic load;
		logic pivot;
		logic select_row;
		logic count;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic edge_ok;
		logic n_zero;
		logic pivot_last;
		logic count_last;
	} stat_t;

	// Population count of one byte.
	function automatic logic [3:0] pop8(input logic [7:0] v);
		logic [3:0] c;
		c = 4'd0;
		for (int b = 0; b < 8; b++) begin
			c = c + {3'd0, v[b]};
		end
		return c;
	endfunction

endpackage

/* hw/rtl/gre_datapath.sv */
module gre_datapath #(
	parameter int NODES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [6:0]          cfg_data,
	input  logic [5:0]          source_node,
	input  logic [5:0]          target_node,
	input  gre_pkg::cmd_t       cmd,
	output gre_pkg::stat_t      stat,
	output logic                reachable,
	output logic [6:0]          reach_count
);

	localparam int IW  = $clog2(NODES);
	localparam int CW  = $clog2(NODES + 1);
	localparam int XW  = (IW > 6) ? IW : 6;
	localparam int EW  = (CW > 6) ? CW : 6;
	localparam int MW  = (CW > 7) ? CW : 7;
	localparam int SW  = (CW > 7) ? CW : 7;
	localparam int NCH = (NODES + 7) / 8;
	localparam int RW  = NCH * 8;
	localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;

	logic [CW-1:0]    n_q;
	logic [NODES-1:0] adj_q   [NODES];
	logic [NODES-1:0] reach_q [NODES];
	logic [NODES-1:0] load_rows [NODES];
	logic [NODES-1:0] piv_rows  [NODES];
	logic [NODES-1:0] pivot_row;
	logic [IW-1:0]    k_q;
	logic [5:0]       src_q;
	logic [5:0]       dst_q;
	logic [RW-1:0]    row_q;
	logic             hit_q;
	logic [CW-1:0]    acc_q;
	logic [CHW-1:0]   chunk_q;
	logic             out_reach_q;
	logic [6:0]       out_count_q;

	logic [MW-1:0]    cfg_ext;
	logic [CW-1:0]    n_next;
	logic [XW-1:0]    e_src_ext;
	logic [XW-1:0]    e_dst_ext;
	logic [XW-1:0]    q_src_ext;
	logic [XW-1:0]    q_dst_ext;
	logic [IW-1:0]    e_src_idx;
	logic [IW-1:0]    e_dst_idx;
	logic [IW-1:0]    q_src_idx;
	logic [IW-1:0]    q_dst_idx;
	logic             q_src_ok;
	logic             q_dst_ok;
	logic [CW-1:0]    n_less1;
	logic [IW-1:0]    k_last;
	logic [SW-1:0]    acc_ext;

	// Effective node count is the written value capped at the matrix size.
	assign cfg_ext = MW'(cfg_data);
	assign n_next  = (cfg_ext < MW'(NODES)) ? cfg_ext[CW-1:0] : CW'(NODES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (cfg_we) begin
			n_q <= n_next;
		end
	end

	// Index and range decoding for the edge inputs and the captured query.
	assign e_src_ext = XW'(source_node);
	assign e_dst_ext = XW'(target_node);
	assign q_src_ext = XW'(src_q);
	assign q_dst_ext = XW'(dst_q);
	assign e_src_idx = e_src_ext[IW-1:0];
	assign e_dst_idx = e_dst_ext[IW-1:0];
	assign q_src_idx = q_src_ext[IW-1:0];
	assign q_dst_idx = q_dst_ext[IW-1:0];
	assign q_src_ok  = EW'(src_q) < EW'(n_q);
	assign q_dst_ok  = EW'(dst_q) < EW'(n_q);

	assign stat.edge_ok = (EW'(source_node) < EW'(n_q)) && (EW'(target_node) < EW'(n_q));
	assign stat.n_zero  = (n_q == '0);

	// Adjacency matrix: one bit set per edge transfer with both ends in range, all cleared at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_q <= '{default: '0};
		end else if (cmd.clear) begin
			adj_q <= '{default: '0};
		end else if (cmd.add_edge && stat.edge_ok) begin
			adj_q[e_src_idx][e_dst_idx] <= 1'b1;
		end
	end

	// Initial closure rows: active columns of the adjacency plus self loops.
	always_comb begin
		for (int i = 0; i < NODES; i++) begin
			for (int j = 0; j < NODES; j++) begin
				load_rows[i][j] = (i < int'(n_q)) && (j < int'(n_q)) &&
					(adj_q[i][j] || (i == j));
			end
		end
	end

	// One Warshall pivot: every row that reaches the pivot takes its row.
	assign pivot_row = reach_q[k_q];

	always_comb begin
		for (int i = 0; i < NODES; i++) begin
			piv_rows[i] = reach_q[i][k_q] ? (reach_q[i] | pivot_row) : reach_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			reach_q <= load_rows;
		end else if (cmd.pivot) begin
			reach_q <= piv_rows;
		end
	end

	// Pivot counter; the last pivot is the highest active node.
	assign n_less1         = n_q - CW'(1);
	assign k_last          = n_less1[IW-1:0];
	assign stat.pivot_last = (k_q == k_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.load) begin
			k_q <= '0;
		end else if (cmd.pivot) begin
			k_q <= k_q + IW'(1);
		end
	end

	// Query operands are held for the length of the item.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			src_q <= source_node;
			dst_q <= target_node;
		end
	end

	// Row selection and byte-wise population count.
	assign stat.count_last = (chunk_q == CHW'(NCH - 1));

	always_ff @(posedge clk) begin
		if (cmd.select_row) begin
			row_q <= q_src_ok ? RW'(reach_q[q_src_idx]) : '0;
			hit_q <= q_src_ok && q_dst_ok && reach_q[q_src_idx][q_dst_idx];
			acc_q <= '0;
		end else if (cmd.count) begin
			row_q <= row_q >> 8;
			acc_q <= acc_q + CW'(gre_pkg::pop8(row_q[7:0]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= '0;
		end else if (cmd.select_row) begin
			chunk_q <= '0;
		end else if (cmd.count) begin
			chunk_q <= chunk_q + CHW'(1);
		end
	end

	// Output register, loaded when the result transfer slot is free.
	assign acc_ext = SW'(acc_q);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_reach_q <= hit_q;
			out_count_q <= (acc_ext > SW'(gre_pkg::COUNT_MAX)) ?
				gre_pkg::COUNT_MAX : acc_ext[6:0];
		end
	end

	assign reachable   = out_reach_q;
	assign reach_count = out_count_q;

endmodule

/* hw/rtl/gre_ctrl.sv */
module gre_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [1:0]     kind,
	output logic           out_valid,
	input  logic           out_stall,
	output gre_pkg::cmd_t  cmd,
	input  gre_pkg::stat_t stat
);

	gre_pkg::state_t state_q;
	gre_pkg::state_t state_d;
	logic            reach_valid_q;
	logic            reach_valid_d;
	logic            out_valid_q;
	logic            valid_now;
	logic            in_xfer;

	assign in_stall  = (state_q != gre_pkg::ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign valid_now = reach_valid_q && !cfg_we;
	assign out_valid = out_valid_q;

	// State, closure flag and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= gre_pkg::ST_IDLE;
			reach_valid_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			reach_valid_q <= reach_valid_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d       = state_q;
		reach_valid_d = valid_now;
		cmd           = '0;
		unique case (state_q)
			gre_pkg::ST_IDLE: begin
				if (in_xfer) begin
					unique case (kind)
						gre_pkg::KIND_ADD: begin
							cmd.add_edge = 1'b1;
							if (stat.edge_ok) begin
								reach_valid_d = 1'b0;
							end
						end
						gre_pkg::KIND_CLEAR: begin
							cmd.clear     = 1'b1;
							reach_valid_d = 1'b0;
						end
						gre_pkg::KIND_QUERY: begin
							cmd.capture = 1'b1;
							state_d = valid_now ? gre_pkg::ST_SELECT : gre_pkg::ST_LOAD;
						end
						default: begin
						end
					endcase
				end
			end
			gre_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				if (stat.n_zero) begin
					reach_valid_d = 1'b1;
					state_d       = gre_pkg::ST_SELECT;
				end else begin
					state_d = gre_pkg::ST_PIVOT;
				end
			end
			gre_pkg::ST_PIVOT: begin
				cmd.pivot = 1'b1;
				if (stat.pivot_last) begin
					reach_valid_d = 1'b1;
					state_d       = gre_pkg::ST_SELECT;
				end
			end
			gre_pkg::ST_SELECT: begin
				cmd.select_row = 1'b1;
				state_d        = gre_pkg::ST_COUNT;
			end
			gre_pkg::ST_COUNT: begin
				cmd.count = 1'b1;
				if (stat.count_last) begin
					state_d = gre_pkg::ST_DONE;
				end
			end
			gre_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = gre_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gre_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	// The pivot sweep only ends by moving on to row selection.
	a_pivot_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gre_pkg::ST_PIVOT) |=>
		(state_q == gre_pkg::ST_PIVOT || state_q == gre_pkg::ST_SELECT))
		else $error("pivot sweep left to an unexpected state");

	// A finished sweep leaves the closure marked valid.
	a_sweep_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gre_pkg::ST_PIVOT && stat.pivot_last && !cfg_we) |=> reach_valid_q)
		else $error("closure not marked valid after the sweep");

	// A query on a valid closure skips the rebuild.
	a_skip_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && kind == gre_pkg::KIND_QUERY && reach_valid_q && !cfg_we) |=>
		(state_q == gre_pkg::ST_SELECT))
		else $error("rebuild started on a valid closure");

	// A result appears only after the done state.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == gre_pkg::ST_DONE))
		else $error("result raised outside the done state");
`endif

endmodule

/* hw/rtl/graph_reachability_engine_top.sv */
// Add-edge and clear items complete in the cycle they are accepted.
// A query on a valid closure goes through row selection, the byte-wise count and the done state to its result register.
// A query after a graph or count change first rebuilds: a load, then one pivot per
// cycle across all rows for each of the n active nodes; throughput is one query at a time.
// Reset clears the adjacency matrix, the node count, the closure flag and the output valid flag;
// the closure rows are not cleared and are always rebuilt before their first use.
module graph_reachability_engine_top #(
	parameter int NODES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic [5:0] source_node,
	input  logic [5:0] target_node,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       reachable,
	output logic [6:0] reach_count
);

	gre_pkg::cmd_t  cmd;
	gre_pkg::stat_t stat;

	// Sequencer for rebuild, count and result transfer.
	gre_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Matrices, pivot sweep and population count.
	gre_datapath #(
		.NODES (NODES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.source_node (source_node),
		.target_node (target_node),
		.cmd         (cmd),
		.stat        (stat),
		.reachable   (reachable),
		.reach_count (reach_count)
	);

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int NODES = 64;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int IDLE_PCT = 18;
	localparam int HOLD_CYCLES = 300;

	// One item on the input channel; kind stays a raw code so the spare code can be sent.
	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] source_node;
		logic [5:0] target_node;
	} graph_item_t;

	// One answer on the output channel.
	typedef struct packed {
		logic       reachable;
		logic [6:0] reach_count;
	} query_answer_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [6:0] cfg_data = 7'd0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] kind = gre_pkg::KIND_ADD;
	logic [5:0] source_node = 6'd0;
	logic [5:0] target_node = 6'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       reachable;
	logic [6:0] reach_count;

	graph_item_t   stimulus_q[$];
	query_answer_t pending_answers[$];
	graph_item_t   offer;
	query_answer_t want;
	int            mismatch_count = 0;
	bit            no_gaps = 1'b0;
	bit            pressure_go = 1'b0;
	logic          hold_off = 1'b0;

	// Shadow copy of the graph, its closure and the node count register.
	logic [63:0] adj_rows [NODES];
	logic [63:0] closure_rows [NODES];
	bit          closure_ok;
	logic [6:0]  active_cfg;

	graph_reachability_engine_top #(.NODES(NODES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.source_node(source_node),
		.target_node(target_node),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.reachable(reachable),
		.reach_count(reach_count)
	);

	// The clock runs at a 20 ns period.
	always #10 clk = ~clk;

	function automatic int unsigned active_nodes();
		return (active_cfg < NODES) ? active_cfg : NODES;
	endfunction

	// Rebuild the closure: masked adjacency plus self loops, then one pivot at a time.
	task automatic rebuild_closure();
		int unsigned n;
		logic [63:0] col_mask;
		n = active_nodes();
		col_mask = (n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
		for (int i = 0; i < NODES; i++) begin
			closure_rows[i] = (i < n) ? (adj_rows[i] & col_mask) : 64'd0;
			if (i < n)
				closure_rows[i][i] = 1'b1;
		end
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < n; i++) begin
				if (closure_rows[i][k])
					closure_rows[i] = closure_rows[i] | closure_rows[k];
			end
		end
		closure_ok = 1'b1;
	endtask

	// Apply one accepted item to the shadow graph; a query also queues its answer.
	task automatic apply_graph_item(input graph_item_t it);
		int unsigned n;
		int c;
		logic hit;
		n = active_nodes();
		case (it.kind)
			gre_pkg::KIND_CLEAR: begin
				for (int i = 0; i < NODES; i++) begin
					adj_rows[i] = 64'd0;
					closure_rows[i] = 64'd0;
				end
				closure_ok = 1'b0;
			end
			gre_pkg::KIND_ADD: begin
				if (it.source_node < n && it.target_node < n) begin
					adj_rows[it.source_node][it.target_node] = 1'b1;
					closure_ok = 1'b0;
				end
			end
			gre_pkg::KIND_QUERY: begin
				if (!closure_ok)
					rebuild_closure();
				c = 0;
				hit = 1'b0;
				if (it.source_node < n) begin
					c = $countones(closure_rows[it.source_node]);
					hit = (it.target_node < n) && closure_rows[it.source_node][it.target_node];
				end
				if (c > int'(gre_pkg::COUNT_MAX))
					c = int'(gre_pkg::COUNT_MAX);
				pending_answers.push_back('{hit, 7'(c)});
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input int got, input int exp);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, exp);
		mismatch_count++;
	endtask

	task automatic push_item(input logic [1:0] k, input logic [5:0] s, input logic [5:0] t);
		stimulus_q.push_back('{k, s, t});
	endtask

	// Mostly active nodes, sometimes any index so that out-of-range ends appear.
	function automatic logic [5:0] pick_node(input int unsigned n);
		if (n == 0 || $urandom_range(9) == 0)
			return 6'($urandom_range(63));
		return 6'($urandom_range(n - 1));
	endfunction

	// Random traffic: edge building dominates, with queries, rare clears and spare codes.
	task automatic push_random_items(input int unsigned count);
		graph_item_t it;
		int unsigned roll;
		int unsigned n;
		n = active_nodes();
		for (int j = 0; j < count; j++) begin
			roll = $urandom_range(99);
			if (roll < 57)
				it.kind = gre_pkg::KIND_ADD;
			else if (roll < 92)
				it.kind = gre_pkg::KIND_QUERY;
			else if (roll < 96)
				it.kind = gre_pkg::KIND_CLEAR;
			else
				it.kind = KIND_SPARE;
			it.source_node = pick_node(n);
			// Chains of neighbors give long paths for the closure sweep.
			if (it.kind == gre_pkg::KIND_ADD && $urandom_range(3) == 0)
				it.target_node = it.source_node + 6'd1;
			else
				it.target_node = pick_node(n);
			stimulus_q.push_back(it);
		end
	endtask

	// Wait for every item to go and every answer to return, then let the block settle.
	task automatic wait_until_idle();
		do
			@(negedge clk);
		while (stimulus_q.size() != 0 || in_valid || pending_answers.size() != 0);
		repeat (NODES + 16) @(posedge clk);
	endtask

	task automatic write_node_count(input logic [6:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		active_cfg = value;
		closure_ok = 1'b0;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Input driver: one transfer per accepted item, random gaps between items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= gre_pkg::KIND_ADD;
			source_node <= 6'd0;
			target_node <= 6'd0;
		end else begin
			if (in_valid && !in_stall)
				apply_graph_item(offer);
			if (!in_valid || !in_stall) begin
				if (stimulus_q.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
					offer = stimulus_q.pop_front();
					in_valid <= 1'b1;
					kind <= offer.kind;
					source_node <= offer.source_node;
					target_node <= offer.target_node;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: check each transfer against the oldest answer, then pick the next stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_answers.size() == 0) begin
					report_mismatch("unexpected result", reach_count, -1);
				end else begin
					want = pending_answers.pop_front();
					if (reachable !== want.reachable)
						report_mismatch("reachable", reachable, want.reachable);
					if (reach_count !== want.reach_count)
						report_mismatch("reach_count", reach_count, want.reach_count);
				end
			end
			if (hold_off)
				out_stall <= 1'b1;
			else if (!no_gaps && $urandom_range(99) < IDLE_PCT)
				out_stall <= 1'b1;
			else
				out_stall <= 1'b0;
		end
	end

	// Long receiver hold-off so the block fills up and stalls its input.
	initial begin
		wait (pressure_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Stimulus and phase sequencing.
	initial begin : stimulus
		int unsigned node_counts [10] = '{1, 64, 2, 127, 16, 0, 7, 40, 3, 64};
		for (int i = 0; i < NODES; i++) begin
			adj_rows[i] = 64'd0;
			closure_rows[i] = 64'd0;
		end
		closure_ok = 1'b0;
		active_cfg = 7'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// No active nodes: every query answers zero and edges are dropped.
		push_item(gre_pkg::KIND_QUERY, 6'd0, 6'd0);
		push_item(gre_pkg::KIND_ADD, 6'd0, 6'd0);
		push_item(gre_pkg::KIND_QUERY, 6'd63, 6'd63);
		push_item(KIND_SPARE, 6'd5, 6'd9);
		wait_until_idle();

		// Count above the node limit, so all 64 nodes are active.
		write_node_count(7'd127);
		push_item(gre_pkg::KIND_ADD, 6'd0, 6'd63);
		push_item(gre_pkg::KIND_ADD, 6'd63, 6'd5);
		push_item(gre_pkg::KIND_ADD, 6'd5, 6'd5);
		push_item(gre_pkg::KIND_QUERY, 6'd0, 6'd5);
		push_item(gre_pkg::KIND_QUERY, 6'd63, 6'd0);
		push_item(gre_pkg::KIND_QUERY, 6'd63, 6'd63);
		push_item(gre_pkg::KIND_QUERY, 6'd0, 6'd0);
		push_item(gre_pkg::KIND_CLEAR, 6'd0, 6'd0);
		push_item(gre_pkg::KIND_QUERY, 6'd0, 6'd63);
		push_item(KIND_SPARE, 6'd63, 6'd63);
		wait_until_idle();

		// Partial count: edges with an inactive end, queries with an inactive end.
		write_node_count(7'd10);
		push_item(gre_pkg::KIND_ADD, 6'd3, 6'd12);
		push_item(gre_pkg::KIND_ADD, 6'd12, 6'd3);
		push_item(gre_pkg::KIND_ADD, 6'd3, 6'd4);
		push_item(gre_pkg::KIND_ADD, 6'd8, 6'd9);
		push_item(gre_pkg::KIND_QUERY, 6'd3, 6'd12);
		push_item(gre_pkg::KIND_QUERY, 6'd12, 6'd3);
		push_item(gre_pkg::KIND_QUERY, 6'd3, 6'd4);
		wait_until_idle();

		// Shrinking the count hides a stored edge; growing it brings the edge back.
		write_node_count(7'd5);
		push_item(gre_pkg::KIND_QUERY, 6'd8, 6'd9);
		push_item(gre_pkg::KIND_ADD, 6'd4, 6'd0);
		push_item(gre_pkg::KIND_QUERY, 6'd3, 6'd0);
		wait_until_idle();
		write_node_count(7'd64);
		push_item(gre_pkg::KIND_QUERY, 6'd8, 6'd9);
		wait_until_idle();

		// Random phases over a sweep of counts, one without gaps and one under pressure.
		for (int p = 0; p < 10; p++) begin
			write_node_count(7'(node_counts[p]));
			no_gaps = (p == 1);
			push_random_items(40);
			if (p == 4)
				pressure_go = 1'b1;
			wait_until_idle();
		end
		no_gaps = 1'b0;

		if (mismatch_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/gre_pkg.sv
hw/rtl/gre_datapath.sv
hw/rtl/gre_ctrl.sv
hw/rtl/graph_reachability_engine_top.sv
verif/tb_top.sv
